// ----- src/sapq_pkg.sv -----
// shared types and constants of the sorted-array priority queue
`timescale 1ns / 1ps

package sapq_pkg;

  // number of cells in the row
  localparam int unsigned Depth = 8;
  // count register width, able to hold Depth itself
  localparam int unsigned CntW = $clog2(Depth + 1);

  // operation codes of the kind field
  localparam logic KindInsert = 1'b0;
  localparam logic KindRemove = 1'b1;

  typedef enum logic [1:0] {
    StInserted = 2'd0,
    StInsFull  = 2'd1,
    StRemoved  = 2'd2,
    StRemEmpty = 2'd3
  } status_e;

  // one held entry
  typedef struct packed {
    logic signed [31:0] payload;
    logic signed [15:0] rank;
  } entry_t;

  // input item
  typedef struct packed {
    logic               kind;
    logic signed [31:0] payload;
    logic signed [15:0] rank;
  } in_t;

  // result item
  typedef struct packed {
    status_e            status;
    logic signed [31:0] out_payload;
    logic signed [15:0] out_rank;
    logic [3:0]         occupancy;
  } out_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t item;
  } ctrl_t;

endpackage

// ----- src/sapq_cell.sv -----
// one cell of the sorted row: holds an entry, shifts right on insert, left on remove
`timescale 1ns / 1ps

module sapq_cell (
  input  logic             clk_i,
  input  sapq_pkg::ctrl_t  ctrl_i,
  input  logic             occ_i,
  input  sapq_pkg::entry_t left_i,
  input  logic             left_shift_i,
  input  sapq_pkg::entry_t right_i,
  output sapq_pkg::entry_t entry_o,
  output logic             shift_o
);

  sapq_pkg::entry_t entry_q, entry_d;

  // held entry leaves after the new one: it moves one place right on insert
  assign shift_o = occ_i && (entry_q.rank > ctrl_i.item.rank);

  // next entry
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (left_shift_i) begin
        entry_d = left_i;
      end else if (shift_o || !occ_i) begin
        entry_d = ctrl_i.item;
      end
    end else if (ctrl_i.rem) begin
      entry_d = right_i;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ----- src/sorted_array_priority_queue.sv -----
// top level of the sorted-array priority queue: cell row, count and result register
`timescale 1ns / 1ps

// channel   | ports                   | transfer
// ----------+-------------------------+-----------------------------------------
// command   | start_i, busy_o, in_i   | edge with start_i high and busy_o low
// result    | done_o, out_o           | edge ending the single cycle done_o is high
//
// One item is taken every cycle; busy_o stays low since every cell of the row
// compares and shifts in the same cycle as the command.
// The result shows on out_o in the cycle after its transfer, for one cycle only.
// Reset clears the entry count and the result strobe; entries need no clearing.
// The receiver cannot stall: a result not taken in its cycle is gone.

module sorted_array_priority_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  sapq_pkg::in_t  in_i,
  output logic           done_o,
  output sapq_pkg::out_t out_o
);

  logic [sapq_pkg::CntW-1:0] count_q, count_d;
  logic                      done_q;
  sapq_pkg::out_t            out_q, out_d;
  sapq_pkg::ctrl_t           ctrl;
  logic                      fire, is_full, is_empty;
  logic [sapq_pkg::CntW+3:0] occ_ext;

  sapq_pkg::entry_t          entries [sapq_pkg::Depth];
  logic                      shifts  [sapq_pkg::Depth];

  assign busy_o   = 1'b0;
  assign fire     = start_i && !busy_o;
  assign is_full  = (count_q == sapq_pkg::CntW'(sapq_pkg::Depth));
  assign is_empty = (count_q == '0);

  // command broadcast to the row
  always_comb begin
    ctrl.ins          = fire && (in_i.kind == sapq_pkg::KindInsert) && !is_full;
    ctrl.rem          = fire && (in_i.kind == sapq_pkg::KindRemove) && !is_empty;
    ctrl.item.payload = in_i.payload;
    ctrl.item.rank    = in_i.rank;
  end

  // cell row
  for (genvar i = 0; i < sapq_pkg::Depth; i++) begin : g_cell
    sapq_pkg::entry_t left_e, right_e;
    logic             left_sh, occ;

    assign occ = (count_q > sapq_pkg::CntW'(i));

    if (i == 0) begin : g_head
      assign left_e  = ctrl.item;
      assign left_sh = 1'b0;
    end else begin : g_mid
      assign left_e  = entries[i-1];
      assign left_sh = shifts[i-1];
    end

    if (i == sapq_pkg::Depth - 1) begin : g_tail
      assign right_e = entries[i];
    end else begin : g_body
      assign right_e = entries[i+1];
    end

    sapq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occ_i        (occ),
      .left_i       (left_e),
      .left_shift_i (left_sh),
      .right_i      (right_e),
      .entry_o      (entries[i]),
      .shift_o      (shifts[i])
    );
  end

  // count update and result
  always_comb begin
    count_d           = count_q;
    out_d.status      = sapq_pkg::StInserted;
    out_d.out_payload = '0;
    out_d.out_rank    = '0;
    unique case (in_i.kind)
      sapq_pkg::KindInsert: begin
        if (is_full) begin
          out_d.status = sapq_pkg::StInsFull;
        end else begin
          count_d = count_q + 1'b1;
        end
      end
      sapq_pkg::KindRemove: begin
        if (is_empty) begin
          out_d.status = sapq_pkg::StRemEmpty;
        end else begin
          out_d.status      = sapq_pkg::StRemoved;
          out_d.out_payload = entries[0].payload;
          out_d.out_rank    = entries[0].rank;
          count_d           = count_q - 1'b1;
        end
      end
      default: ;
    endcase
    occ_ext         = {4'b0, count_d};
    out_d.occupancy = occ_ext[3:0];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= fire;
      if (fire) begin
        count_q <= count_d;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign done_o = done_q;
  assign out_o  = out_q;

`ifndef SYNTHESIS
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> (done_o == $past(start_i && !busy_o)))
    else $error("result strobe does not follow command transfer");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= sapq_pkg::CntW'(sapq_pkg::Depth))
    else $error("entry count above depth");

  a_full_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && out_o.status == sapq_pkg::StInsFull) |->
      (count_q == sapq_pkg::CntW'(sapq_pkg::Depth)))
    else $error("full rejection while not full");

  a_empty_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && out_o.status == sapq_pkg::StRemEmpty) |-> (count_q == '0))
    else $error("empty rejection while entries held");
`endif

endmodule

// ----- tb/sapq_order_check.sv -----
// checker for the sorted-array priority queue: shadow queue, result compare, tallies
`timescale 1ns / 1ps

module sapq_order_check (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           busy_i,
  input  sapq_pkg::in_t  in_i,
  input  logic           done_i,
  input  sapq_pkg::out_t out_i,
  output int             fault_count_o,
  output int             owed_count_o,
  output int             inserted_o,
  output int             full_o,
  output int             removed_o,
  output int             empty_o
);

  import sapq_pkg::*;

  // shadow copy of the sorted row and its fill level
  entry_t shadow_entries [Depth];
  int     shadow_count;

  // replies owed by the block, oldest first
  out_t   owed_replies [$];

  int     faults;
  int     n_inserted, n_full, n_removed, n_empty;
  out_t   reply_due;
  out_t   reply_got;

  // apply one command to the shadow queue and return the reply it causes
  function automatic out_t step_shadow_queue(input in_t cmd);
    out_t res;
    int   pos;
    res = '0;
    if (cmd.kind == KindInsert) begin
      if (shadow_count >= Depth) begin
        res.status = StInsFull;
      end else begin
        // walk past every held entry of greater rank, so ties keep arrival order
        pos = shadow_count;
        while (pos > 0 && $signed(shadow_entries[pos-1].rank) > $signed(cmd.rank)) begin
          shadow_entries[pos] = shadow_entries[pos-1];
          pos--;
        end
        shadow_entries[pos].payload = cmd.payload;
        shadow_entries[pos].rank    = cmd.rank;
        shadow_count++;
        res.status = StInserted;
      end
    end else if (shadow_count == 0) begin
      res.status = StRemEmpty;
    end else begin
      // head leaves, the rest moves down one place
      res.out_payload = shadow_entries[0].payload;
      res.out_rank    = shadow_entries[0].rank;
      for (int i = 0; i + 1 < shadow_count; i++) begin
        shadow_entries[i] = shadow_entries[i+1];
      end
      shadow_count--;
      res.status = StRemoved;
    end
    res.occupancy = shadow_count[3:0];
    return res;
  endfunction

  // count a fault, report only the first few
  function automatic void note_fault(input out_t due, input out_t got, input bit orphan);
    faults++;
    if (faults <= 10) begin
      if (orphan) begin
        $display("%0t: result with nothing owed: status %0d payload %h rank %h occ %0d",
                 $realtime, got.status, got.out_payload, got.out_rank, got.occupancy);
      end else begin
        $display("%0t: mismatch: due status %0d payload %h rank %h occ %0d", $realtime,
                 due.status, due.out_payload, due.out_rank, due.occupancy);
        $display("%0t:           got status %0d payload %h rank %h occ %0d", $realtime,
                 got.status, got.out_payload, got.out_rank, got.occupancy);
      end
    end
  endfunction

  // predict on each command transfer, compare on each result transfer
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      shadow_count = 0;
      owed_replies.delete();
    end else begin
      if (start_i && !busy_i) begin
        reply_due = step_shadow_queue(in_i);
        owed_replies.push_back(reply_due);
        case (reply_due.status)
          StInserted: n_inserted++;
          StInsFull:  n_full++;
          StRemoved:  n_removed++;
          default:    n_empty++;
        endcase
      end
      if (done_i) begin
        reply_got = out_i;
        if (owed_replies.size() == 0) begin
          note_fault(reply_got, reply_got, 1'b1);
        end else begin
          reply_due = owed_replies.pop_front();
          if (reply_got.status !== reply_due.status ||
              reply_got.out_payload !== reply_due.out_payload ||
              reply_got.out_rank !== reply_due.out_rank ||
              reply_got.occupancy !== reply_due.occupancy) begin
            note_fault(reply_due, reply_got, 1'b0);
          end
        end
      end
    end
    fault_count_o <= faults;
    owed_count_o  <= owed_replies.size();
    inserted_o    <= n_inserted;
    full_o        <= n_full;
    removed_o     <= n_removed;
    empty_o       <= n_empty;
  end

  initial begin
    faults       = 0;
    shadow_count = 0;
    n_inserted   = 0;
    n_full       = 0;
    n_removed    = 0;
    n_empty      = 0;
  end

endmodule

// ----- tb/sorted_array_priority_queue_tb.sv -----
// testbench top of the sorted-array priority queue: clock, reset, commands, verdict
`timescale 1ns / 1ps

module sorted_array_priority_queue_tb;

  import sapq_pkg::*;

  logic clk_i;
  logic rst_ni;
  logic start_i;
  logic busy_o;
  in_t  in_i;
  logic done_o;
  out_t out_o;

  int fault_count, owed_count;
  int n_inserted, n_full, n_removed, n_empty;
  int sent;
  int burst_left, fill_bias, gap;
  logic pick_kind;

  sorted_array_priority_queue dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .in_i    (in_i),
    .done_o  (done_o),
    .out_o   (out_o)
  );

  sapq_order_check order_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_i        (busy_o),
    .in_i          (in_i),
    .done_i        (done_o),
    .out_i         (out_o),
    .fault_count_o (fault_count),
    .owed_count_o  (owed_count),
    .inserted_o    (n_inserted),
    .full_o        (n_full),
    .removed_o     (n_removed),
    .empty_o       (n_empty)
  );

  // 50 MHz clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // hard stop in case the run hangs
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // present one command and hold it until its transfer
  task automatic send_cmd(input logic kind, input logic [31:0] pay, input logic [15:0] rk);
    in_t cmd;
    cmd.kind    = kind;
    cmd.payload = pay;
    cmd.rank    = rk;
    start_i <= 1'b1;
    in_i    <= cmd;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sent++;
  endtask

  // ranks mostly from a narrow band so ties are common, with extremes mixed in
  function automatic logic [15:0] pick_rank();
    case ($urandom_range(9))
      6, 7:    return 16'($urandom);
      8:       return $urandom_range(1) ? 16'h8000 : 16'h7fff;
      9:       return 16'($urandom_range(2)) - 16'd1;
      default: return 16'($urandom_range(6)) - 16'd3;
    endcase
  endfunction

  function automatic logic [31:0] pick_payload();
    case ($urandom_range(15))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // stimulus
  initial begin
    sent       = 0;
    burst_left = 0;
    fill_bias  = 50;
    rst_ni  <= 1'b0;
    start_i <= 1'b0;
    in_i    <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty remove, extremes, equal ranks, full insert, drain past empty
    send_cmd(KindRemove, 32'hdead_beef, 16'h1234);
    send_cmd(KindInsert, 32'h7fff_ffff, 16'h7fff);
    send_cmd(KindInsert, 32'h8000_0000, 16'h8000);
    send_cmd(KindInsert, 32'h0000_0000, 16'h0000);
    send_cmd(KindInsert, 32'hffff_ffff, 16'hffff);
    send_cmd(KindInsert, 32'h0000_0001, 16'h0005);
    send_cmd(KindInsert, 32'h0000_0002, 16'h0005);
    send_cmd(KindInsert, 32'h0000_0003, 16'h0005);
    send_cmd(KindInsert, 32'h5555_5555, 16'h8000);
    send_cmd(KindInsert, 32'haaaa_aaaa, 16'h8000);
    for (int i = 0; i < Depth; i++) begin
      send_cmd(KindRemove, $urandom, 16'($urandom));
    end
    send_cmd(KindRemove, 32'hffff_ffff, 16'hffff);

    // wait for the queue of replies to drain once
    start_i <= 1'b0;
    @(posedge clk_i);
    while (owed_count != 0) @(posedge clk_i);

    // random: bursts with a per-burst lean toward filling, draining or neither
    for (int n = 0; n < 1600; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(24, 1);
        case ($urandom_range(2))
          0:       fill_bias = 80;
          1:       fill_bias = 20;
          default: fill_bias = 50;
        endcase
        gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
        if (gap > 0) begin
          start_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      // midway, hold off until every reply is back
      if (n == 800) begin
        start_i <= 1'b0;
        @(posedge clk_i);
        while (owed_count != 0) @(posedge clk_i);
      end
      pick_kind = ($urandom_range(99) < fill_bias) ? KindInsert : KindRemove;
      send_cmd(pick_kind, pick_payload(), pick_rank());
      burst_left--;
    end

    // drain and settle
    start_i <= 1'b0;
    for (int w = 0; w < 200 && owed_count != 0; w++) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("covered %0d commands: %0d inserts, %0d full rejects, %0d removes, %0d empty rejects",
             sent, n_inserted, n_full, n_removed, n_empty);
    if (fault_count == 0 && owed_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d faults, %0d replies never arrived", fault_count, owed_count);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
